/* hdl/sod_pkg.sv */
// Package for the signal onset detector: window sizes, derived widths and
// the shared sample and verdict types. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sod_pkg;

   localparam int PRE_WINDOW  = 100;
   localparam int POST_WINDOW = 10;
   localparam int HIST_DEPTH  = PRE_WINDOW + POST_WINDOW + 1;

   localparam int SAMPLE_W = 16;
   localparam int IDX_W    = 20;
   localparam int STEP_W   = $clog2(HIST_DEPTH);
   // Holds the sum of the post-window and POST_WINDOW times any sample.
   localparam int SUM_W    = SAMPLE_W + $clog2(POST_WINDOW);

   localparam logic [IDX_W-1:0]  IDX_MAX   = '1;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(HIST_DEPTH - 1);

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] drag;
      logic signed [SAMPLE_W-1:0] lift;
   } sample_pair_type;

   typedef struct packed {
      logic                       drag_hit;
      logic                       lift_hit;
      logic signed [SAMPLE_W-1:0] drag_value;
      logic signed [SAMPLE_W-1:0] lift_value;
   } verdict_type;

endpackage

`default_nettype wire

/* hdl/sod_channels.sv */
// Valid/ready channel interfaces for the sample requests and the onset
// responses. Depends on sod_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sod_req_if;
   import sod_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       restart;
   logic signed [SAMPLE_W-1:0] drag_sample;
   logic signed [SAMPLE_W-1:0] lift_sample;

   modport source (output valid, output restart, output drag_sample,
                   output lift_sample, input ready);
   modport sink   (input valid, input restart, input drag_sample,
                   input lift_sample, output ready);
endinterface

interface sod_rsp_if;
   import sod_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       drag_found;
   logic [IDX_W-1:0]           drag_start_index;
   logic signed [SAMPLE_W-1:0] drag_start_value;
   logic                       lift_found;
   logic [IDX_W-1:0]           lift_start_index;
   logic signed [SAMPLE_W-1:0] lift_start_value;
   logic                       window_full;

   modport source (output valid, output drag_found, output drag_start_index,
                   output drag_start_value, output lift_found,
                   output lift_start_index, output lift_start_value,
                   output window_full, input ready);
   modport sink   (input valid, input drag_found, input drag_start_index,
                   input drag_start_value, input lift_found,
                   input lift_start_index, input lift_start_value,
                   input window_full, output ready);
endinterface

`default_nettype wire

/* hdl/sod_cell.sv */
// One history cell: holds a drag/lift sample pair and takes its
// neighbor's pair whenever the ring shifts. Depends on sod_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sod_cell (
   input  wire                       clock,
   input  wire                       shift,
   input  sod_pkg::sample_pair_type  pair_in,
   output sod_pkg::sample_pair_type  pair_out
);
   import sod_pkg::*;

   sample_pair_type pair_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         pair_ff <= pair_in;
      end
   end

   assign pair_out = pair_ff;

endmodule

`default_nettype wire

/* hdl/sod_judge.sv */
// Accumulator at the tail of the cell ring: builds the pre-window extremes,
// the candidate pair and the post-window sums, and forms the onset verdict.
// Depends on sod_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sod_judge (
   input  wire                       clock,
   input  wire                       step_valid,
   input  wire [sod_pkg::STEP_W-1:0] step,
   input  sod_pkg::sample_pair_type  tail,
   output sod_pkg::verdict_type      verdict
);
   import sod_pkg::*;

   localparam logic [STEP_W-1:0]      CAND_STEP = STEP_W'(PRE_WINDOW);
   localparam logic signed [SUM_W-1:0] POST_MULT = SUM_W'(POST_WINDOW);

   logic signed [SAMPLE_W-1:0] drag_max_ff;
   logic signed [SAMPLE_W-1:0] lift_min_ff;
   logic signed [SAMPLE_W-1:0] drag_cand_ff;
   logic signed [SAMPLE_W-1:0] lift_cand_ff;
   logic signed [SUM_W-1:0]    drag_sum_ff;
   logic signed [SUM_W-1:0]    lift_sum_ff;
   logic signed [SUM_W-1:0]    drag_bound;
   logic signed [SUM_W-1:0]    lift_bound;

   // The tail shows the oldest sample first: the pre-window, then the
   // candidate, then the post-window.
   always_ff @(posedge clock) begin
      if (step_valid) begin
         if (step == '0) begin
            drag_max_ff <= tail.drag;
            lift_min_ff <= tail.lift;
         end else if (step < CAND_STEP) begin
            if (tail.drag > drag_max_ff) begin
               drag_max_ff <= tail.drag;
            end
            if (tail.lift < lift_min_ff) begin
               lift_min_ff <= tail.lift;
            end
         end
         if (step == CAND_STEP) begin
            drag_cand_ff <= tail.drag;
            lift_cand_ff <= tail.lift;
            drag_sum_ff  <= '0;
            lift_sum_ff  <= '0;
         end else if (step > CAND_STEP) begin
            drag_sum_ff <= drag_sum_ff + SUM_W'(tail.drag);
            lift_sum_ff <= lift_sum_ff + SUM_W'(tail.lift);
         end
      end
   end

   assign drag_bound = SUM_W'(drag_max_ff) * POST_MULT;
   assign lift_bound = SUM_W'(lift_min_ff) * POST_MULT;

   assign verdict.drag_hit   = drag_sum_ff > drag_bound;
   assign verdict.lift_hit   = lift_sum_ff < lift_bound;
   assign verdict.drag_value = drag_cand_ff;
   assign verdict.lift_value = lift_cand_ff;

endmodule

`default_nettype wire

/* hdl/signal_onset_detector.sv */
// Top level of the signal onset detector: ring of history cells, tail
// judge, control sequencer and response register.
// Depends on sod_pkg, sod_channels, sod_cell and sod_judge.
//
//   Channel   Direction   Beat contents
//   req_bus   in          restart flag, drag sample, lift sample
//   rsp_bus   out         drag/lift found, onset indices and values, window full
//
// Once the history is full an item pushes the new pair, rotates the 111-cell
// ring once past the judge at its tail, and then decides and loads the
// response. Before that it pushes the pair and then decides straight away.
// Reset clears the sequencer, the sample counter and the onset latches;
// history cells are never read before 111 samples have refilled them.
// A stalled response beat blocks only the decide cycle of the next item:
// a new request beat is taken while the previous response still waits.
`timescale 1ns / 1ps
`default_nettype none

module signal_onset_detector (
   input  wire       clock,
   input  wire       reset,
   sod_req_if.sink   req_bus,
   sod_rsp_if.source rsp_bus
);
   import sod_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [IDX_W-1:0]           counter_ff, counter_in;
   logic [IDX_W-1:0]           cand_ff, cand_in;
   logic                       full_ff, full_in;
   logic                       drag_latched_ff, drag_latched_in;
   logic                       lift_latched_ff, lift_latched_in;
   logic [IDX_W-1:0]           drag_index_ff, drag_index_in;
   logic [IDX_W-1:0]           lift_index_ff, lift_index_in;
   logic signed [SAMPLE_W-1:0] drag_value_ff, drag_value_in;
   logic signed [SAMPLE_W-1:0] lift_value_ff, lift_value_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_load;

   logic                       rsp_drag_found_ff;
   logic [IDX_W-1:0]           rsp_drag_index_ff;
   logic signed [SAMPLE_W-1:0] rsp_drag_value_ff;
   logic                       rsp_lift_found_ff;
   logic [IDX_W-1:0]           rsp_lift_index_ff;
   logic signed [SAMPLE_W-1:0] rsp_lift_value_ff;
   logic                       rsp_full_ff;

   logic                       req_accept;
   logic                       rsp_free;
   logic [IDX_W-1:0]           sample_num;
   logic                       shift_en;
   sample_pair_type            head_pair;
   sample_pair_type            chain [HIST_DEPTH];
   verdict_type                verdict;

   // The cells form a ring. A push feeds the new pair into cell 0 and drops
   // the oldest; a rotation step feeds the last cell back into cell 0, so a
   // full turn leaves the history where it was.
   assign req_accept = req_bus.valid && req_bus.ready;
   assign shift_en   = req_accept || (state_ff == ST_SCAN);

   always_comb begin
      if (state_ff == ST_SCAN) begin
         head_pair = chain[HIST_DEPTH-1];
      end else begin
         head_pair.drag = req_bus.drag_sample;
         head_pair.lift = req_bus.lift_sample;
      end
   end

   for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_cell
      if (k == 0) begin : g_head
         sod_cell u_cell (
            .clock    (clock),
            .shift    (shift_en),
            .pair_in  (head_pair),
            .pair_out (chain[k])
         );
      end else begin : g_body
         sod_cell u_cell (
            .clock    (clock),
            .shift    (shift_en),
            .pair_in  (chain[k-1]),
            .pair_out (chain[k])
         );
      end
   end

   // The judge sees the oldest pair first, so step 0 is the far end of the
   // pre-window and the last step is the newest sample.
   sod_judge u_judge (
      .clock      (clock),
      .step_valid (state_ff == ST_SCAN),
      .step       (step_ff),
      .tail       (chain[HIST_DEPTH-1]),
      .verdict    (verdict)
   );

   // A restart beat counts as the first sample of a fresh run.
   assign sample_num = req_bus.restart ? '0 : counter_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_load   = (state_ff == ST_FINISH) && rsp_free;

   always_comb begin
      state_in        = state_ff;
      step_in         = step_ff;
      counter_in      = counter_ff;
      cand_in         = cand_ff;
      full_in         = full_ff;
      drag_latched_in = drag_latched_ff;
      lift_latched_in = lift_latched_ff;
      drag_index_in   = drag_index_ff;
      lift_index_in   = lift_index_ff;
      drag_value_in   = drag_value_ff;
      lift_value_in   = lift_value_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_bus.restart) begin
                  drag_latched_in = 1'b0;
                  lift_latched_in = 1'b0;
                  drag_index_in   = '0;
                  lift_index_in   = '0;
                  drag_value_in   = '0;
                  lift_value_in   = '0;
               end
               // The counter saturates; a candidate taken after that
               // reports the top index.
               counter_in = (sample_num == IDX_MAX) ? sample_num : sample_num + 1'b1;
               full_in    = sample_num >= IDX_W'(PRE_WINDOW + POST_WINDOW);
               cand_in    = (sample_num == IDX_MAX) ? IDX_MAX
                                                    : sample_num - IDX_W'(POST_WINDOW);
               step_in    = '0;
               state_in   = full_in ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               // Only the first hit on each channel is kept.
               if (full_ff && !drag_latched_ff && verdict.drag_hit) begin
                  drag_latched_in = 1'b1;
                  drag_index_in   = cand_ff;
                  drag_value_in   = verdict.drag_value;
               end
               if (full_ff && !lift_latched_ff && verdict.lift_hit) begin
                  lift_latched_in = 1'b1;
                  lift_index_in   = cand_ff;
                  lift_value_in   = verdict.lift_value;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         step_ff         <= '0;
         counter_ff      <= '0;
         cand_ff         <= '0;
         full_ff         <= 1'b0;
         drag_latched_ff <= 1'b0;
         lift_latched_ff <= 1'b0;
         drag_index_ff   <= '0;
         lift_index_ff   <= '0;
         drag_value_ff   <= '0;
         lift_value_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         step_ff         <= step_in;
         counter_ff      <= counter_in;
         cand_ff         <= cand_in;
         full_ff         <= full_in;
         drag_latched_ff <= drag_latched_in;
         lift_latched_ff <= lift_latched_in;
         drag_index_ff   <= drag_index_in;
         lift_index_ff   <= lift_index_in;
         drag_value_ff   <= drag_value_in;
         lift_value_ff   <= lift_value_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      // The response payload follows the latches as they leave the
      // decide cycle.
      if (rsp_load) begin
         rsp_drag_found_ff <= drag_latched_in;
         rsp_drag_index_ff <= drag_index_in;
         rsp_drag_value_ff <= drag_value_in;
         rsp_lift_found_ff <= lift_latched_in;
         rsp_lift_index_ff <= lift_index_in;
         rsp_lift_value_ff <= lift_value_in;
         rsp_full_ff       <= full_ff;
      end
   end

   assign req_bus.ready            = (state_ff == ST_IDLE);
   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.drag_found       = rsp_drag_found_ff;
   assign rsp_bus.drag_start_index = rsp_drag_index_ff;
   assign rsp_bus.drag_start_value = rsp_drag_value_ff;
   assign rsp_bus.lift_found       = rsp_lift_found_ff;
   assign rsp_bus.lift_start_index = rsp_lift_index_ff;
   assign rsp_bus.lift_start_value = rsp_lift_value_ff;
   assign rsp_bus.window_full      = rsp_full_ff;

   // A full ring turn always ends in the decide cycle.
   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && step_ff == LAST_STEP) |=> (state_ff == ST_FINISH))
      else $error("ring walk did not end in the decide cycle");

   // An onset latch only drops on a restart beat.
   a_drag_kept: assert property (@(posedge clock) disable iff (reset)
      (drag_latched_ff && !(req_accept && req_bus.restart)) |=> drag_latched_ff)
      else $error("drag onset latch dropped without restart");

   a_lift_kept: assert property (@(posedge clock) disable iff (reset)
      (lift_latched_ff && !(req_accept && req_bus.restart)) |=> lift_latched_ff)
      else $error("lift onset latch dropped without restart");

   // A response is loaded only when the output slot is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_valid_ff) |-> rsp_bus.ready)
      else $error("pending response overwritten");

endmodule

`default_nettype wire

/* bench/sod_onset_checker.sv */
// Scoreboard for the signal onset detector: watches both channels, keeps its
// own copy of the sample history and onset latches, and compares every response.
// Depends on sod_pkg and sod_channels.
`timescale 1ns / 1ps

module sod_onset_checker (
   input  wire clock,
   input  wire reset,
   sod_req_if  req_bus,
   sod_rsp_if  rsp_bus,
   output int  mismatch_count,
   output int  pending,
   output int  full_windows,
   output int  drag_onsets,
   output int  lift_onsets
);
   import sod_pkg::*;

   typedef struct packed {
      logic                       drag_found;
      logic [IDX_W-1:0]           drag_index;
      logic signed [SAMPLE_W-1:0] drag_value;
      logic                       lift_found;
      logic [IDX_W-1:0]           lift_index;
      logic signed [SAMPLE_W-1:0] lift_value;
      logic                       window_full;
   } onset_report_type;

   // Index 0 holds the newest pair.
   logic signed [SAMPLE_W-1:0] drag_hist [HIST_DEPTH];
   logic signed [SAMPLE_W-1:0] lift_hist [HIST_DEPTH];
   logic [IDX_W-1:0]           pairs_taken;
   logic                       drag_held, lift_held;
   logic [IDX_W-1:0]           drag_at, lift_at;
   logic signed [SAMPLE_W-1:0] drag_level, lift_level;

   onset_report_type awaited_reports [$];
   int mismatches = 0;
   int full_seen  = 0;
   int drag_seen  = 0;
   int lift_seen  = 0;

   function void clear_history();
      for (int k = 0; k < HIST_DEPTH; k++) begin
         drag_hist[k] = '0;
         lift_hist[k] = '0;
      end
      pairs_taken = '0;
      drag_held   = 1'b0;
      lift_held   = 1'b0;
      drag_at     = '0;
      lift_at     = '0;
      drag_level  = '0;
      lift_level  = '0;
   endfunction

   // Shifts one pair in and evaluates the candidate POST_WINDOW pairs back.
   task take_sample_pair(input logic restart, input logic signed [SAMPLE_W-1:0] drag,
                         input logic signed [SAMPLE_W-1:0] lift);
      logic [IDX_W-1:0]           index_now;
      logic [IDX_W-1:0]           cand;
      logic signed [SAMPLE_W-1:0] peak;
      logic signed [SAMPLE_W-1:0] trough;
      longint                     drag_sum;
      longint                     lift_sum;
      onset_report_type           rpt;
      if (restart)
         clear_history();
      index_now = pairs_taken;
      for (int k = HIST_DEPTH - 1; k > 0; k--) begin
         drag_hist[k] = drag_hist[k-1];
         lift_hist[k] = lift_hist[k-1];
      end
      drag_hist[0] = drag;
      lift_hist[0] = lift;
      if (pairs_taken != IDX_MAX)
         pairs_taken++;

      rpt.window_full = (index_now >= IDX_W'(PRE_WINDOW + POST_WINDOW));
      if (rpt.window_full) begin
         cand = (index_now == IDX_MAX) ? IDX_MAX : index_now - IDX_W'(POST_WINDOW);
         full_seen++;
         if (!drag_held) begin
            peak = drag_hist[POST_WINDOW+1];
            for (int k = POST_WINDOW + 2; k < HIST_DEPTH; k++)
               if (drag_hist[k] > peak)
                  peak = drag_hist[k];
            drag_sum = 0;
            for (int k = 0; k < POST_WINDOW; k++)
               drag_sum += drag_hist[k];
            if (drag_sum > longint'(POST_WINDOW) * longint'(peak)) begin
               drag_held  = 1'b1;
               drag_at    = cand;
               drag_level = drag_hist[POST_WINDOW];
               drag_seen++;
            end
         end
         if (!lift_held) begin
            trough = lift_hist[POST_WINDOW+1];
            for (int k = POST_WINDOW + 2; k < HIST_DEPTH; k++)
               if (lift_hist[k] < trough)
                  trough = lift_hist[k];
            lift_sum = 0;
            for (int k = 0; k < POST_WINDOW; k++)
               lift_sum += lift_hist[k];
            if (lift_sum < longint'(POST_WINDOW) * longint'(trough)) begin
               lift_held  = 1'b1;
               lift_at    = cand;
               lift_level = lift_hist[POST_WINDOW];
               lift_seen++;
            end
         end
      end

      rpt.drag_found = drag_held;
      rpt.drag_index = drag_at;
      rpt.drag_value = drag_level;
      rpt.lift_found = lift_held;
      rpt.lift_index = lift_at;
      rpt.lift_value = lift_level;
      awaited_reports.push_back(rpt);
   endtask

   task check_field(input string field, input logic signed [31:0] want,
                    input logic signed [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   task compare_report(input onset_report_type want);
      check_field("drag_found",       32'(want.drag_found), 32'(rsp_bus.drag_found));
      check_field("drag_start_index", 32'(want.drag_index), 32'(rsp_bus.drag_start_index));
      check_field("drag_start_value", 32'(want.drag_value), 32'(rsp_bus.drag_start_value));
      check_field("lift_found",       32'(want.lift_found), 32'(rsp_bus.lift_found));
      check_field("lift_start_index", 32'(want.lift_index), 32'(rsp_bus.lift_start_index));
      check_field("lift_start_value", 32'(want.lift_value), 32'(rsp_bus.lift_start_value));
      check_field("window_full",      32'(want.window_full), 32'(rsp_bus.window_full));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_history();
         awaited_reports.delete();
      end else begin
         // Requests first: a response at the same edge belongs to an older beat.
         if (req_bus.valid && req_bus.ready)
            take_sample_pair(req_bus.restart, req_bus.drag_sample, req_bus.lift_sample);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_reports.size() == 0) begin
               mismatches++;
               $display("%0t: response beat mismatch, expected none, actual one", $time);
            end else begin
               compare_report(awaited_reports.pop_front());
            end
         end
      end
      mismatch_count <= mismatches;
      pending        <= awaited_reports.size();
      full_windows   <= full_seen;
      drag_onsets    <= drag_seen;
      lift_onsets    <= lift_seen;
   end

endmodule

/* bench/signal_onset_detector_tb.sv */
// Testbench top for the signal onset detector: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict. Depends on sod_pkg, sod_channels,
// signal_onset_detector and sod_onset_checker.
`timescale 1ns / 1ps

module signal_onset_detector_tb;
   import sod_pkg::*;

   // Number of random sample beats after the directed opening.
   localparam int RANDOM_PAIRS = 1600;
   // The slowest correct beat is a full sender gap, a full-window item and a full
   // response stall, one after another.
   // The watchdog allows many times that without a single accepted beat.
   localparam int QUIET_LIMIT = 2000;
   // After the last response, give the block one more full item time to show
   // any spurious beat.
   localparam int SETTLE_CYCLES = 120;

   logic clock = 1'b0;
   logic reset;

   sod_req_if req_bus ();
   sod_rsp_if rsp_bus ();

   int mismatch_count;
   int pending;
   int full_windows;
   int drag_onsets;
   int lift_onsets;

   int sent_pairs  = 0;
   int window_runs = 0;
   int quiet_cycles = 0;
   // While a calm flag is set that side never idles, which gives stretches of
   // back-to-back beats between the randomly gapped ones.
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;

   always #1 clock = ~clock;

   signal_onset_detector uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   sod_onset_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .mismatch_count (mismatch_count),
      .pending        (pending),
      .full_windows   (full_windows),
      .drag_onsets    (drag_onsets),
      .lift_onsets    (lift_onsets)
   );

   // Saturates an integer into the signed 16-bit converter range.
   function automatic logic signed [SAMPLE_W-1:0] clip(input int v);
      if (v > 32767)
         v = 32767;
      else if (v < -32768)
         v = -32768;
      return SAMPLE_W'(v);
   endfunction

   // A resting level for one channel; the rails come up often so that the
   // comparisons are exercised at the extremes of the sample range.
   function automatic int pick_level();
      case ($urandom_range(0, 5))
         0: return -32768;
         1: return 32767;
         default: return int'($urandom_range(0, 40000)) - 20000;
      endcase
   endfunction

   // Noise amplitude: none, fine, moderate or coarse.
   function automatic int pick_spread();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return int'($urandom_range(1, 8));
         2: return int'($urandom_range(9, 300));
         default: return int'($urandom_range(301, 4000));
      endcase
   endfunction

   function automatic int jitter(input int spread);
      return int'($urandom_range(0, 2 * spread)) - spread;
   endfunction

   // Sends one sample beat. Valid is lowered only when a gap is drawn, so a
   // beat that follows straight on keeps valid high across the edge.
   task automatic send_pair(input bit restart, input logic signed [SAMPLE_W-1:0] drag,
                            input logic signed [SAMPLE_W-1:0] lift);
      int gap;
      if ($urandom_range(0, 63) == 0)
         req_calm = !req_calm;
      gap = req_calm ? 0 : int'($urandom_range(0, 17));
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.restart     <= restart;
      req_bus.drag_sample <= drag;
      req_bus.lift_sample <= lift;
      do
         @(posedge clock);
      while (!req_bus.ready);
      sent_pairs++;
   endtask

   // One measurement: a quiet stretch around a resting level, then a step on
   // each channel, then a return to rest. The step usually goes up on drag and
   // down on lift, which is what the detector looks for, but either channel may
   // step the wrong way so that only one of them, or neither, latches. A quiet
   // stretch shorter than the pre-window makes the step land before a full
   // window has been seen.
   task automatic run_window(input bit fresh, input int calm_len);
      int drag_base;
      int lift_base;
      int spread;
      int drag_step;
      int lift_step;
      int rise_len;
      int tail_len;
      bit first;
      window_runs++;
      drag_base = pick_level();
      lift_base = pick_level();
      spread    = pick_spread();
      drag_step = ($urandom_range(0, 4) == 0) ? -int'($urandom_range(0, 2000))
                                              : int'($urandom_range(1, 6000));
      lift_step = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 2000))
                                              : -int'($urandom_range(1, 6000));
      first = fresh;
      for (int k = 0; k < calm_len; k++) begin
         send_pair(first, clip(drag_base + jitter(spread)), clip(lift_base + jitter(spread)));
         first = 1'b0;
      end
      rise_len = $urandom_range(1, 25);
      for (int k = 0; k < rise_len; k++)
         send_pair(1'b0, clip(drag_base + drag_step + jitter(spread / 4)),
                   clip(lift_base + lift_step + jitter(spread / 4)));
      tail_len = $urandom_range(0, 15);
      for (int k = 0; k < tail_len; k++)
         send_pair(1'b0, clip(drag_base + jitter(spread)), clip(lift_base + jitter(spread)));
   endtask

   // Fully random beats with the odd restart mixed in.
   task automatic run_noise();
      int count;
      count = $urandom_range(1, 40);
      for (int k = 0; k < count; k++)
         send_pair($urandom_range(0, 15) == 0, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
   endtask

   initial begin : stimulus
      int directed_pairs;
      req_bus.valid       <= 1'b0;
      req_bus.restart     <= 1'b0;
      req_bus.drag_sample <= '0;
      req_bus.lift_sample <= '0;
      reset <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed opening. Everything here is short history: no candidate is
      // evaluated yet, so the latches must stay clear while the samples swing
      // between the rails and restarts arrive with nothing latched.
      // 16'sh7FFF and 16'sh8000 are the positive and negative rails.
      send_pair(1'b0, 16'sh7FFF, 16'sh8000);
      send_pair(1'b0, 16'sh8000, 16'sh7FFF);
      send_pair(1'b0, 16'sh0000, 16'sh0000);
      send_pair(1'b0, 16'shFFFF, 16'sh0001);
      send_pair(1'b0, 16'sh5555, -16'sh5556);
      send_pair(1'b0, -16'sh5556, 16'sh5555);
      send_pair(1'b1, 16'shFFFF, 16'sh0001);
      send_pair(1'b1, 16'sh7FFF, 16'sh7FFF);
      send_pair(1'b0, 16'sh8000, 16'sh8000);
      send_pair(1'b1, 16'sh0000, 16'shFFFF);
      send_pair(1'b0, 16'sh0001, 16'sh0000);
      send_pair(1'b1, 16'sh8000, 16'sh7FFF);
      directed_pairs = sent_pairs;

      // Random part. Most of it is complete measurements that fill the window
      // and then step, since only those reach the onset comparisons.
      while (sent_pairs - directed_pairs < RANDOM_PAIRS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: run_window(1'b1, $urandom_range(100, 140));
            6:                run_window(1'b0, $urandom_range(100, 140));
            7:                run_window(1'b1, $urandom_range(5, 99));
            default:          run_noise();
         endcase
      end
      req_bus.valid <= 1'b0;

      // Let the checker's pending count catch up with the last request beat
      // before it is trusted.
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d sample beats (%0d directed) in %0d measurement runs.",
               sent_pairs, directed_pairs, window_runs);
      $display("%0d beats evaluated a full window; %0d drag and %0d lift onsets latched.",
               full_windows, drag_onsets, lift_onsets);
      if (mismatch_count == 0 && pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Response side: after each accepted beat, draw how long to hold ready low.
   // The hold counts either every cycle or only cycles in which a response is
   // offered, so stalls land both between items and on a waiting response.
   initial begin : response_sink
      int  hold;
      bit  count_always;
      hold         = 0;
      count_always = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if ($urandom_range(0, 63) == 0)
               rsp_calm = !rsp_calm;
            hold         = rsp_calm ? 0 : int'($urandom_range(0, 17));
            count_always = 1'($urandom_range(0, 1));
            if (hold != 0)
               rsp_bus.ready <= 1'b0;
         end else if (!rsp_bus.ready) begin
            if (hold != 0 && (rsp_bus.valid || count_always))
               hold--;
            if (hold == 0)
               rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog: any accepted beat on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles, %0d responses outstanding",
                  $time, QUIET_LIMIT, pending);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
